/* rtl/matrix3_inverse_unit_defines.svh */
// ----------------------------------------------------------------------------
// Matrix3 inverse unit assertion macros
// Shared assertion forms for the checker of the 3x3 matrix inverse unit.
// ----------------------------------------------------------------------------
`ifndef MATRIX3_INVERSE_UNIT_DEFINES_SVH
`define MATRIX3_INVERSE_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk_i and quiet while rst_ni is low.
`define MI3_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, clocked on clk_i and quiet while rst_ni is low.
`define MI3_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/mi3_pkg.sv */
// ----------------------------------------------------------------------------
// Matrix3 inverse package
// Widths, index tables, shared types and the divider step functions.
// ----------------------------------------------------------------------------
`default_nettype none

package mi3_pkg;

  localparam int unsigned IN_FRAC_BITS  = 14;
  localparam int unsigned OUT_FRAC_BITS = 16;

  localparam int unsigned NUM_ELEM  = 9;
  localparam int unsigned ELEM_W    = 16;
  localparam int unsigned RES_W     = 32;
  localparam int unsigned IN_W      = NUM_ELEM * ELEM_W;
  localparam int unsigned OUT_W     = NUM_ELEM * RES_W;

  localparam int unsigned PROD_W    = 2 * ELEM_W;
  localparam int unsigned COF_W     = PROD_W + 1;
  localparam int unsigned DETP_W    = ELEM_W + COF_W;
  localparam int unsigned DET_W     = DETP_W + 2;
  // |det| < 3 * 2^46, so 48 magnitude bits are enough.
  localparam int unsigned DMAG_W    = 48;
  localparam int unsigned R_W       = DMAG_W + 1;
  localparam int unsigned NUM_MAG_W = 33;
  localparam int unsigned Q_W       = RES_W + 1;

  localparam int unsigned SHIFT     = IN_FRAC_BITS + OUT_FRAC_BITS;
  localparam int unsigned DIV_STEPS = NUM_MAG_W + SHIFT;
  localparam int unsigned LAST_STEP = DIV_STEPS - 1;

  localparam int unsigned FRONT_STAGES = 4;
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned FIFO_AW      = 2;

  // Adjugate entry k = m[t0]*m[t1] - m[t2]*m[t3], row-major order.
  localparam logic [3:0] ADJ_TERM [NUM_ELEM][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd3, 4'd2, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  // Adjugate entries that pair with the first row in the determinant.
  localparam logic [3:0] DET_COF [3] = '{4'd0, 4'd3, 4'd6};

  typedef struct packed {
    logic                               singular;
    logic [NUM_ELEM-1:0]                neg;
    logic [DMAG_W-1:0]                  dmag;
    logic [NUM_ELEM-1:0][NUM_MAG_W-1:0] amag;
  } front_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [DMAG_W-1:0]    rem;
    logic [NUM_MAG_W-1:0] dvd;
    logic [Q_W-1:0]       quo;
    logic                 sat;
  } lane_t;

  typedef struct packed {
    logic                       singular;
    logic [NUM_ELEM-1:0]        neg;
    logic [DMAG_W-1:0]          dmag;
    lane_t [NUM_ELEM-1:0]       lane;
  } div_stage_t;

  // Largest magnitude a result may take for the given sign.
  function automatic logic [Q_W-1:0] lane_limit(input logic neg);
    logic [Q_W-1:0] top;
    top = Q_W'(1) << (RES_W - 1);
    return neg ? top : top - Q_W'(1);
  endfunction

  // One restoring division step: one quotient bit.
  function automatic lane_t div_step(input lane_t l, input logic [DMAG_W-1:0] d,
                                     input logic neg);
    logic [R_W-1:0] r_sh;
    logic [R_W-1:0] diff;
    logic           ge;
    logic [Q_W:0]   qx;
    lane_t          o;
    r_sh  = {l.rem, l.dvd[NUM_MAG_W-1]};
    ge    = r_sh >= {1'b0, d};
    diff  = r_sh - {1'b0, d};
    o.rem = ge ? diff[DMAG_W-1:0] : r_sh[DMAG_W-1:0];
    o.dvd = {l.dvd[NUM_MAG_W-2:0], 1'b0};
    qx    = {l.quo, ge};
    if (l.sat) begin
      o.quo = l.quo;
      o.sat = 1'b1;
    end else begin
      o.quo = qx[Q_W-1:0];
      o.sat = qx > {1'b0, lane_limit(neg)};
    end
    return o;
  endfunction

  function automatic div_stage_t stage_step(input div_stage_t s);
    div_stage_t o;
    o = s;
    for (int k = 0; k < NUM_ELEM; k++) begin
      o.lane[k] = div_step(s.lane[k], s.dmag, s.neg[k]);
    end
    return o;
  endfunction

  // Round to nearest (ties away from zero), saturate, then apply the sign; a singular matrix gives zero.
  function automatic logic [RES_W-1:0] lane_result(input lane_t l,
                                                   input logic [DMAG_W-1:0] d,
                                                   input logic neg,
                                                   input logic singular);
    logic [Q_W-1:0] lim;
    logic [Q_W-1:0] qr;
    logic [Q_W-1:0] neg_q;
    logic           rnd;
    lim   = lane_limit(neg);
    rnd   = !l.sat && (l.rem >= d - l.rem);
    qr    = l.quo + Q_W'(rnd);
    if (l.sat || qr > lim) begin
      qr = lim;
    end
    neg_q = Q_W'(0) - qr;
    if (singular) begin
      return '0;
    end
    return neg ? neg_q[RES_W-1:0] : qr[RES_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/mi3_front.sv */
// ----------------------------------------------------------------------------
// Matrix3 inverse front end
// Accepts matrices and forms the adjugate, determinant and operand signs.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  input  logic [mi3_pkg::IN_W-1:0] s_data_i,
  input  mi3_pkg::q_status_t    q_status_i,
  output logic                  push_o,
  output mi3_pkg::front_word_t  word_o
);
  import mi3_pkg::*;

  logic                      en;
  logic [FRONT_STAGES-1:0]   v_q;
  logic signed [ELEM_W-1:0]  m      [NUM_ELEM];
  logic signed [PROD_W-1:0]  pp_q   [NUM_ELEM];
  logic signed [PROD_W-1:0]  pn_q   [NUM_ELEM];
  logic signed [ELEM_W-1:0]  r0a_q  [3];
  logic signed [ELEM_W-1:0]  r0b_q  [3];
  logic signed [COF_W-1:0]   adj_q  [NUM_ELEM];
  logic signed [COF_W-1:0]   adj2_q [NUM_ELEM];
  logic signed [DETP_W-1:0]  dp_q   [3];
  front_word_t               word_d;
  front_word_t               word_q;

  always_comb begin
    for (int k = 0; k < NUM_ELEM; k++) begin
      m[k] = s_data_i[k*ELEM_W +: ELEM_W];
    end
  end

  // The whole front advances together; it halts only when its last word
  // cannot enter the queue.
  assign en        = !v_q[FRONT_STAGES-1] || !q_status_i.full;
  assign s_ready_o = en;
  assign push_o    = v_q[FRONT_STAGES-1] && !q_status_i.full;
  assign word_o    = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[FRONT_STAGES-2:0], s_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NUM_ELEM; k++) begin
        pp_q[k]   <= m[ADJ_TERM[k][0]] * m[ADJ_TERM[k][1]];
        pn_q[k]   <= m[ADJ_TERM[k][2]] * m[ADJ_TERM[k][3]];
        adj_q[k]  <= COF_W'(pp_q[k]) - COF_W'(pn_q[k]);
        adj2_q[k] <= adj_q[k];
      end
      for (int j = 0; j < 3; j++) begin
        r0a_q[j] <= m[j];
        r0b_q[j] <= r0a_q[j];
        dp_q[j]  <= r0b_q[j] * adj_q[DET_COF[j]];
      end
      word_q <= word_d;
    end
  end

  always_comb begin
    logic signed [DET_W-1:0] det_s;
    logic signed [DET_W-1:0] det_abs;
    logic signed [COF_W-1:0] adj_abs;
    logic                    det_neg;
    det_s           = DET_W'(dp_q[0]) + DET_W'(dp_q[1]) + DET_W'(dp_q[2]);
    det_neg         = det_s[DET_W-1];
    det_abs         = det_neg ? -det_s : det_s;
    word_d.singular = (det_s == '0);
    word_d.dmag     = det_abs[DMAG_W-1:0];
    for (int k = 0; k < NUM_ELEM; k++) begin
      adj_abs           = adj2_q[k][COF_W-1] ? -adj2_q[k] : adj2_q[k];
      word_d.neg[k]     = adj2_q[k][COF_W-1] ^ det_neg;
      word_d.amag[k]    = adj_abs[NUM_MAG_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/mi3_fifo.sv */
// ----------------------------------------------------------------------------
// Matrix3 inverse work queue
// Short queue that decouples the front end from the divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mi3_pkg::front_word_t word_i,
  input  logic                 pop_i,
  output mi3_pkg::front_word_t word_o,
  output mi3_pkg::q_status_t   status_o
);
  import mi3_pkg::*;

  front_word_t          mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wptr_q;
  logic [FIFO_AW-1:0]   rptr_q;
  logic [FIFO_AW:0]     cnt_q;

  assign word_o         = mem_q[rptr_q];
  assign status_o.full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign status_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + FIFO_AW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + FIFO_AW'(1);
      end
      cnt_q <= cnt_q + (FIFO_AW+1)'(push_i) - (FIFO_AW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= word_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/mi3_back.sv */
// ----------------------------------------------------------------------------
// Matrix3 inverse back end
// Pipelined restoring divider, one quotient bit per stage, nine lanes wide.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mi3_pkg::front_word_t     word_i,
  input  mi3_pkg::q_status_t       q_status_i,
  output logic                     pop_o,
  output logic                     m_valid_o,
  input  logic                     m_ready_i,
  output logic [mi3_pkg::OUT_W-1:0] m_data_o,
  output logic                     m_user_o
);
  import mi3_pkg::*;

  logic                   en;
  div_stage_t             init_s;
  div_stage_t             nxt  [DIV_STEPS];
  div_stage_t             st_q [DIV_STEPS];
  logic [DIV_STEPS-1:0]   sv_q;
  logic                   out_valid_q;
  logic [OUT_W-1:0]       data_q;
  logic                   user_q;

  assign en        = !out_valid_q || m_ready_i;
  assign pop_o     = en && !q_status_i.empty;
  assign m_valid_o = out_valid_q;
  assign m_data_o  = data_q;
  assign m_user_o  = user_q;

  always_comb begin
    init_s.singular = word_i.singular;
    init_s.neg      = word_i.neg;
    init_s.dmag     = word_i.dmag;
    for (int k = 0; k < NUM_ELEM; k++) begin
      init_s.lane[k].rem = '0;
      init_s.lane[k].dvd = word_i.amag[k];
      init_s.lane[k].quo = '0;
      init_s.lane[k].sat = 1'b0;
    end
    nxt[0] = stage_step(init_s);
    for (int s = 1; s < DIV_STEPS; s++) begin
      nxt[s] = stage_step(st_q[s-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      sv_q        <= {sv_q[DIV_STEPS-2:0], !q_status_i.empty};
      out_valid_q <= sv_q[LAST_STEP];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < DIV_STEPS; s++) begin
        st_q[s] <= nxt[s];
      end
      for (int k = 0; k < NUM_ELEM; k++) begin
        data_q[k*RES_W +: RES_W] <= lane_result(st_q[LAST_STEP].lane[k],
                                                st_q[LAST_STEP].dmag,
                                                st_q[LAST_STEP].neg[k],
                                                st_q[LAST_STEP].singular);
      end
      user_q <= st_q[LAST_STEP].singular;
    end
  end

endmodule

`default_nettype wire

/* rtl/matrix3_inverse_unit.sv */
// ----------------------------------------------------------------------------
// Matrix3 inverse unit
// Inverse of a signed Q2.14 3x3 matrix as saturated, rounded Q16.16 values.
// ----------------------------------------------------------------------------
// Usage. One matrix enters per word on the s_axis channel and one inverse
// leaves per word on the m_axis channel, in the same order. A word moves on
// a rising edge of clk_i at which tvalid and tready are both high.
// Throughput is one matrix per cycle as long as m_axis_tready stays high.
// Without stalls, a matrix passes from the accepting edge to m_axis_tvalid
// through four front-end stages that form the adjugate and the determinant,
// a queue entry, and 63 divider stages that each produce one quotient bit,
// followed by the output register.
// A zero determinant raises m_axis_tuser and all nine results read zero.
// Reset (rst_ni low, asynchronous) empties every stage and the queue; the
// unit keeps no state between matrices. When the receiver stalls, the
// divider pipeline freezes while the front end keeps accepting until the
// four-entry queue is full and a word waits at the end of the front end;
// only then s_axis_tready falls.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix3_inverse_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // tdata, from bit 0 up: a00 a01 a02 a10 a11 a12 a20 a21 a22, 16 bits each
  input  logic [mi3_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // tdata, from bit 0 up: inv00 inv01 inv02 inv10 inv11 inv12 inv20 inv21
  // inv22, 32 bits each
  output logic [mi3_pkg::OUT_W-1:0] m_axis_tdata,
  // tuser: singular
  output logic                      m_axis_tuser
);
  import mi3_pkg::*;

  // Classified words travel from the front end through the queue.
  front_word_t front_word;
  front_word_t queue_word;
  q_status_t   q_status;
  logic        push;
  logic        pop;

  mi3_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_data_i   (s_axis_tdata),
    .q_status_i (q_status),
    .push_o     (push),
    .word_o     (front_word)
  );

  // The queue lets the front end run on while the divider is held.
  mi3_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .word_i   (front_word),
    .pop_i    (pop),
    .word_o   (queue_word),
    .status_o (q_status)
  );

  // The divider advances whenever the output register is free or drained.
  mi3_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .word_i     (queue_word),
    .q_status_i (q_status),
    .pop_o      (pop),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata),
    .m_user_o   (m_axis_tuser)
  );

endmodule

`default_nettype wire

/* rtl/mi3_checker.sv */
// ----------------------------------------------------------------------------
// Matrix3 inverse port checker
// Watches the ports of the inverse unit and flags illegal behavior.
// ----------------------------------------------------------------------------
`default_nettype none

`include "matrix3_inverse_unit_defines.svh"

module mi3_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [mi3_pkg::OUT_W-1:0] m_axis_tdata,
  input  logic                      m_axis_tuser
);
  import mi3_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [7:0] cnt_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Matrices accepted but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 8'(in_acc) - 8'(out_acc);
    end
  end

  `MI3_ASSERT_IMP(a_singular_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
  `MI3_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `MI3_ASSERT_IMP(a_no_orphan, m_axis_tvalid, cnt_q != '0)
  `MI3_ASSERT_IMP(a_idle_ready, cnt_q == '0, s_axis_tready)

endmodule

bind matrix3_inverse_unit mi3_checker u_mi3_checker (.*);

`default_nettype wire
